// ----- sv/tspd_pkg.sv -----
// ----------------------------------------------------------------------------
// tspd_pkg: shared types and constants for the passage direction unit
// codes, log entry layout, result record and the saturating increment
// ----------------------------------------------------------------------------
package tspd_pkg;

    localparam int unsigned LOG_DEPTH     = 32;
    localparam int unsigned LOG_ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int unsigned HELD_W        = $clog2(LOG_DEPTH + 1);
    localparam logic [15:0] WINDOW_RESET  = 16'd750;
    localparam logic [15:0] CNT_MAX       = 16'hFFFF;

    typedef logic [15:0]           cnt16_t;
    typedef logic [5:0]            log_count_t;
    typedef logic [HELD_W-1:0]     held_t;
    typedef logic [LOG_ADDR_W-1:0] log_addr_t;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_RIGHT = 3'd2,
        MODE_READ  = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PASS   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_BEYOND = 2'd2
    } kind_t;

    typedef enum logic {
        DIR_LEFTWARD  = 1'b0,
        DIR_RIGHTWARD = 1'b1
    } dir_t;

    typedef struct packed {
        logic        direction;
        logic [15:0] gap_ticks;
        logic [31:0] stamp;
    } log_entry_t;

    typedef struct packed {
        kind_t       kind;
        log_entry_t  entry;
        cnt16_t      left_seen;
        cnt16_t      right_seen;
        cnt16_t      passes_leftward;
        cnt16_t      passes_rightward;
        logic        stored;
        log_count_t  log_count;
    } result_t;

    function automatic cnt16_t sat_inc(input cnt16_t v);
        sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ----- sv/tspd_ram.sv -----
// ----------------------------------------------------------------------------
// tspd_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tspd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/two_sensor_passage_direction_unit.sv -----
// ----------------------------------------------------------------------------
// two_sensor_passage_direction_unit: passage direction from two motion sensors
// ----------------------------------------------------------------------------
// Each request is a millisecond tick, a left or right detection, a log read
// or a period clear. A detection from idle arms its side and starts counting
// ticks; a detection on the other side inside window_ms ticks completes a
// passage, which is counted, logged (if the log has room) and reported as one
// result. Log reads return one result, ticks, arming detections, repeats,
// clears and unused modes return none. The unit takes one request per clock
// cycle without gaps while results are taken; a result passes through the p1
// stage, covering the registered read of the log ram, and then the output
// register before it becomes valid on the m_ side. The input stalls only
// while both stages hold a result and m_ready is low. window_ms is to be
// written through the cfg_ port only while the unit is idle; the unit itself
// does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_sensor_passage_direction_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_timestamp,
    input  logic [4:0]  s_entry_index,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_direction,
    output logic [15:0] m_gap_ticks,
    output logic [31:0] m_stamp,
    output logic [15:0] m_left_seen,
    output logic [15:0] m_right_seen,
    output logic [15:0] m_passes_leftward,
    output logic [15:0] m_passes_rightward,
    output logic        m_stored,
    output logic [5:0]  m_log_count
);

    // ------------------------------------------------------------------
    // architectural state
    // ------------------------------------------------------------------
    tspd_pkg::cnt16_t   window_reg;
    tspd_pkg::phase_t   phase_reg,   phase_next;
    tspd_pkg::cnt16_t   elapsed_reg, elapsed_next;
    tspd_pkg::cnt16_t   left_hits_reg,  left_hits_next;
    tspd_pkg::cnt16_t   right_hits_reg, right_hits_next;
    tspd_pkg::cnt16_t   leftward_reg,   leftward_next;
    tspd_pkg::cnt16_t   rightward_reg,  rightward_next;
    tspd_pkg::held_t    held_reg,    held_next;

    // pipeline: p1 waits for the ram read, then the output register
    logic               p1_valid_reg, p1_valid_next;
    tspd_pkg::result_t  p1_res_reg,   p1_res_next;
    logic               m_valid_reg,  m_valid_next;
    tspd_pkg::result_t  m_res_reg,    m_res_next;

    // log ram
    logic                  ram_wr_en;
    tspd_pkg::log_addr_t   ram_wr_addr;
    tspd_pkg::log_entry_t  ram_wr_data;
    logic                  ram_rd_en;
    tspd_pkg::log_entry_t  ram_rd_data;

    logic               accept;
    logic               out_free;
    logic               pass_hit;
    logic               pass_dir;
    logic               in_range;
    logic               room;

    // the output register frees when empty or taken this cycle;
    // p1 may refill whenever it is empty or moves on
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !p1_valid_reg || out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // read in range of the filled part of the log
    assign in_range = (32'(s_entry_index) < 32'(held_reg))
                   && (32'(s_entry_index) < tspd_pkg::LOG_DEPTH);
    assign room     = 32'(held_reg) < tspd_pkg::LOG_DEPTH;

    tspd_ram #(
        .WIDTH ($bits(tspd_pkg::log_entry_t)),
        .DEPTH (tspd_pkg::LOG_DEPTH)
    ) u_log_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (tspd_pkg::log_addr_t'(s_entry_index)),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // next state for one accepted request
    // ------------------------------------------------------------------
    always_comb begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        left_hits_next  = left_hits_reg;
        right_hits_next = right_hits_reg;
        leftward_next   = leftward_reg;
        rightward_next  = rightward_reg;
        held_next       = held_reg;

        // p1 drains into the output register when that frees
        p1_valid_next   = p1_valid_reg && !out_free;
        p1_res_next     = p1_res_reg;

        ram_wr_en       = 1'b0;
        ram_wr_addr     = tspd_pkg::log_addr_t'(held_reg);
        ram_wr_data     = '{direction: 1'b0, gap_ticks: elapsed_reg, stamp: s_timestamp};
        ram_rd_en       = 1'b0;
        pass_hit        = 1'b0;
        pass_dir        = tspd_pkg::DIR_LEFTWARD;

        if (accept) begin
            unique case (tspd_pkg::mode_t'(s_mode))
                tspd_pkg::MODE_TICK: begin
                    if (phase_reg != tspd_pkg::PH_IDLE) begin
                        elapsed_next = tspd_pkg::sat_inc(elapsed_reg);
                        // window closed without a pairing detection
                        if (elapsed_next >= window_reg) begin
                            phase_next = tspd_pkg::PH_IDLE;
                        end
                    end
                end
                tspd_pkg::MODE_LEFT: begin
                    if (phase_reg == tspd_pkg::PH_IDLE) begin
                        phase_next     = tspd_pkg::PH_LEFT;
                        elapsed_next   = '0;
                        left_hits_next = tspd_pkg::sat_inc(left_hits_reg);
                    end else if (phase_reg == tspd_pkg::PH_RIGHT) begin
                        pass_hit = 1'b1;
                        pass_dir = tspd_pkg::DIR_LEFTWARD;
                    end
                end
                tspd_pkg::MODE_RIGHT: begin
                    if (phase_reg == tspd_pkg::PH_IDLE) begin
                        phase_next      = tspd_pkg::PH_RIGHT;
                        elapsed_next    = '0;
                        right_hits_next = tspd_pkg::sat_inc(right_hits_reg);
                    end else if (phase_reg == tspd_pkg::PH_LEFT) begin
                        pass_hit = 1'b1;
                        pass_dir = tspd_pkg::DIR_RIGHTWARD;
                    end
                end
                tspd_pkg::MODE_READ: begin
                    // entry fields come from the registered ram read, merged in at the output register
                    ram_rd_en     = in_range;
                    p1_valid_next = 1'b1;
                    p1_res_next   = '{
                        kind:             in_range ? tspd_pkg::KIND_READ
                                                   : tspd_pkg::KIND_BEYOND,
                        entry:            '0,
                        left_seen:        left_hits_reg,
                        right_seen:       right_hits_reg,
                        passes_leftward:  leftward_reg,
                        passes_rightward: rightward_reg,
                        stored:           1'b0,
                        log_count:        tspd_pkg::log_count_t'(held_reg)
                    };
                end
                tspd_pkg::MODE_CLEAR: begin
                    // phase and elapsed survive a period clear
                    left_hits_next  = '0;
                    right_hits_next = '0;
                    leftward_next   = '0;
                    rightward_next  = '0;
                    held_next       = '0;
                end
                default: begin
                end
            endcase

            // completed passage: count, log if room, report
            if (pass_hit) begin
                phase_next = tspd_pkg::PH_IDLE;
                if (pass_dir == tspd_pkg::DIR_RIGHTWARD) begin
                    right_hits_next = tspd_pkg::sat_inc(right_hits_reg);
                    rightward_next  = tspd_pkg::sat_inc(rightward_reg);
                end else begin
                    left_hits_next  = tspd_pkg::sat_inc(left_hits_reg);
                    leftward_next   = tspd_pkg::sat_inc(leftward_reg);
                end
                ram_wr_data.direction = pass_dir;
                if (room) begin
                    ram_wr_en = 1'b1;
                    held_next = held_reg + tspd_pkg::held_t'(1);
                end
                p1_valid_next = 1'b1;
                p1_res_next   = '{
                    kind:             tspd_pkg::KIND_PASS,
                    entry:            ram_wr_data,
                    left_seen:        left_hits_next,
                    right_seen:       right_hits_next,
                    passes_leftward:  leftward_next,
                    passes_rightward: rightward_next,
                    stored:           room,
                    log_count:        tspd_pkg::log_count_t'(held_next)
                };
            end
        end
    end

    // output register, with the ram data merged in for log reads
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (out_free) begin
            m_valid_next = p1_valid_reg;
            m_res_next   = p1_res_reg;
            if (p1_res_reg.kind == tspd_pkg::KIND_READ) begin
                m_res_next.entry = ram_rd_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= tspd_pkg::WINDOW_RESET;
            phase_reg      <= tspd_pkg::PH_IDLE;
            elapsed_reg    <= '0;
            left_hits_reg  <= '0;
            right_hits_reg <= '0;
            leftward_reg   <= '0;
            rightward_reg  <= '0;
            held_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            left_hits_reg  <= left_hits_next;
            right_hits_reg <= right_hits_next;
            leftward_reg   <= leftward_next;
            rightward_reg  <= rightward_next;
            held_reg       <= held_next;
            p1_valid_reg   <= p1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        p1_res_reg <= p1_res_next;
        m_res_reg  <= m_res_next;
    end

    // ------------------------------------------------------------------
    // result ports
    // ------------------------------------------------------------------
    assign m_valid            = m_valid_reg;
    assign m_kind             = m_res_reg.kind;
    assign m_direction        = m_res_reg.entry.direction;
    assign m_gap_ticks        = m_res_reg.entry.gap_ticks;
    assign m_stamp            = m_res_reg.entry.stamp;
    assign m_left_seen        = m_res_reg.left_seen;
    assign m_right_seen       = m_res_reg.right_seen;
    assign m_passes_leftward  = m_res_reg.passes_leftward;
    assign m_passes_rightward = m_res_reg.passes_rightward;
    assign m_stored           = m_res_reg.stored;
    assign m_log_count        = m_res_reg.log_count;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the log fill count never passes the log depth
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(held_reg) <= tspd_pkg::LOG_DEPTH)
        else $error("log fill count beyond depth");

    // a period clear empties the log fill count and the left hit and rightward passage counters
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == tspd_pkg::MODE_CLEAR) |=>
            (held_reg == '0 && left_hits_reg == '0 && rightward_reg == '0))
        else $error("period clear did not take effect");

    // a leftward pairing detection returns the unit to idle and queues a passage
    a_pass_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == tspd_pkg::MODE_LEFT && phase_reg == tspd_pkg::PH_RIGHT) |=>
            (phase_reg == tspd_pkg::PH_IDLE && p1_valid_reg
             && p1_res_reg.kind == tspd_pkg::KIND_PASS))
        else $error("passage did not complete");

    // a stored passage always leaves a nonempty log
    a_stored_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_res_reg.kind == tspd_pkg::KIND_PASS && m_res_reg.stored)
            |-> (m_res_reg.log_count != '0))
        else $error("stored passage with empty log");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for two_sensor_passage_direction_unit
// a queue-fed driver offers sensor requests in random bursts, a clocked
// monitor takes results under its own stall pattern and checks each one
// against a passage tracker kept in step with every accepted request
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    // generous cycle budget
    localparam int CYCLE_LIMIT = 100_000;
    localparam int HOLD_CYCLES = 300;

    // one sensor request as the bench keeps it
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] ts;
        logic [4:0]  idx;
    } sensor_req_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode        = '0;
    logic [31:0] s_timestamp   = '0;
    logic [4:0]  s_entry_index = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic        m_direction;
    logic [15:0] m_gap_ticks;
    logic [31:0] m_stamp;
    logic [15:0] m_left_seen;
    logic [15:0] m_right_seen;
    logic [15:0] m_passes_leftward;
    logic [15:0] m_passes_rightward;
    logic        m_stored;
    logic [5:0]  m_log_count;

    two_sensor_passage_direction_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_timestamp        (s_timestamp),
        .s_entry_index      (s_entry_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_direction        (m_direction),
        .m_gap_ticks        (m_gap_ticks),
        .m_stamp            (m_stamp),
        .m_left_seen        (m_left_seen),
        .m_right_seen       (m_right_seen),
        .m_passes_leftward  (m_passes_leftward),
        .m_passes_rightward (m_passes_rightward),
        .m_stored           (m_stored),
        .m_log_count        (m_log_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // requests waiting to be offered, results waiting to come out
    sensor_req_t       sensor_reqs[$];
    tspd_pkg::result_t pending_results[$];

    // traffic shaping knobs, written by the sequencer with nonblocking assignments
    bit tx_bursty  = 1'b1;
    bit rx_choppy  = 1'b1;
    int hold_token = 0;

    int err_cnt = 0;
    int n_accepted = 0;
    int n_pass = 0;
    int n_dropped = 0;
    int n_read = 0;
    int n_beyond = 0;

    // ------------------------------------------------------------------------
    // passage tracker: the bench's own copy of the block state
    // ------------------------------------------------------------------------
    tspd_pkg::cnt16_t     tr_window = tspd_pkg::WINDOW_RESET;
    tspd_pkg::phase_t     tr_phase  = tspd_pkg::PH_IDLE;
    tspd_pkg::cnt16_t     tr_elapsed = '0;
    tspd_pkg::cnt16_t     tr_left = '0;
    tspd_pkg::cnt16_t     tr_right = '0;
    tspd_pkg::cnt16_t     tr_leftward = '0;
    tspd_pkg::cnt16_t     tr_rightward = '0;
    int                   tr_held = 0;
    tspd_pkg::log_entry_t tr_log [tspd_pkg::LOG_DEPTH];

    function automatic tspd_pkg::cnt16_t bump16(input tspd_pkg::cnt16_t v);
        bump16 = (v == 16'hFFFF) ? v : tspd_pkg::cnt16_t'(v + 16'd1);
    endfunction

    // second detection on the opposite side: count, log if there is room
    task automatic close_passage(input tspd_pkg::dir_t d, input logic [31:0] ts,
                                 inout tspd_pkg::result_t res);
        begin
            tr_phase = tspd_pkg::PH_IDLE;
            if (d == tspd_pkg::DIR_RIGHTWARD) begin
                tr_right     = bump16(tr_right);
                tr_rightward = bump16(tr_rightward);
            end else begin
                tr_left     = bump16(tr_left);
                tr_leftward = bump16(tr_leftward);
            end
            res.kind            = tspd_pkg::KIND_PASS;
            res.entry.direction = d;
            res.entry.gap_ticks = tr_elapsed;
            res.entry.stamp     = ts;
            res.stored          = 1'b0;
            if (tr_held < int'(tspd_pkg::LOG_DEPTH)) begin
                tr_log[tr_held] = res.entry;
                tr_held++;
                res.stored = 1'b1;
            end else begin
                n_dropped++;
            end
            n_pass++;
        end
    endtask

    // apply one accepted request, queue the result it causes if any
    task automatic advance_tracker(input sensor_req_t rq);
        tspd_pkg::result_t res;
        bit                emit;
        begin
            res  = '0;
            emit = 1'b0;
            case (rq.mode)
                tspd_pkg::MODE_TICK: begin
                    // ticks only matter while one side is armed
                    if (tr_phase != tspd_pkg::PH_IDLE) begin
                        tr_elapsed = bump16(tr_elapsed);
                        if (tr_elapsed >= tr_window)
                            tr_phase = tspd_pkg::PH_IDLE;
                    end
                end
                tspd_pkg::MODE_LEFT: begin
                    if (tr_phase == tspd_pkg::PH_IDLE) begin
                        tr_phase   = tspd_pkg::PH_LEFT;
                        tr_elapsed = '0;
                        tr_left    = bump16(tr_left);
                    end else if (tr_phase == tspd_pkg::PH_RIGHT) begin
                        close_passage(tspd_pkg::DIR_LEFTWARD, rq.ts, res);
                        emit = 1'b1;
                    end
                end
                tspd_pkg::MODE_RIGHT: begin
                    if (tr_phase == tspd_pkg::PH_IDLE) begin
                        tr_phase   = tspd_pkg::PH_RIGHT;
                        tr_elapsed = '0;
                        tr_right   = bump16(tr_right);
                    end else if (tr_phase == tspd_pkg::PH_LEFT) begin
                        close_passage(tspd_pkg::DIR_RIGHTWARD, rq.ts, res);
                        emit = 1'b1;
                    end
                end
                tspd_pkg::MODE_READ: begin
                    emit       = 1'b1;
                    res.stored = 1'b0;
                    if (int'(rq.idx) < tr_held) begin
                        res.kind  = tspd_pkg::KIND_READ;
                        res.entry = tr_log[rq.idx];
                        n_read++;
                    end else begin
                        res.kind  = tspd_pkg::KIND_BEYOND;
                        res.entry = '0;
                        n_beyond++;
                    end
                end
                tspd_pkg::MODE_CLEAR: begin
                    // period counters and log count only, arming is kept
                    tr_left      = '0;
                    tr_right     = '0;
                    tr_leftward  = '0;
                    tr_rightward = '0;
                    tr_held      = 0;
                end
                default: ;
            endcase
            if (emit) begin
                res.left_seen        = tr_left;
                res.right_seen       = tr_right;
                res.passes_leftward  = tr_leftward;
                res.passes_rightward = tr_rightward;
                res.log_count        = tspd_pkg::log_count_t'(tr_held);
                pending_results.push_back(res);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued requests in bursts with random gaps
    // ------------------------------------------------------------------------
    sensor_req_t cur_req;
    int          gap_left   = 0;
    int          burst_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            // request taken at this edge
            if (s_valid && s_ready) begin
                advance_tracker(cur_req);
                n_accepted++;
            end
            // slot is free when nothing is offered or the offer just went in
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sensor_reqs.size() > 0) begin
                    cur_req = sensor_reqs.pop_front();
                    s_valid       <= 1'b1;
                    s_mode        <= cur_req.mode;
                    s_timestamp   <= cur_req.ts;
                    s_entry_index <= cur_req.idx;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (tx_bursty) begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: takes results, compares each against the oldest expectation
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int run_left  = 0;
    bit rx_on     = 1'b1;

    task automatic diff_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        begin
            if (exp_v !== act_v) begin
                err_cnt++;
                $display("%0t mismatch on %s: expected %0h actual %0h",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    task automatic compare_result();
        tspd_pkg::result_t want;
        begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t result with no request pending: %s %0d",
                         $time, "expected none actual kind", m_kind);
            end else begin
                want = pending_results.pop_front();
                diff_field("kind", 32'(want.kind), 32'(m_kind));
                diff_field("direction", 32'(want.entry.direction), 32'(m_direction));
                diff_field("gap_ticks", 32'(want.entry.gap_ticks), 32'(m_gap_ticks));
                diff_field("stamp", want.entry.stamp, m_stamp);
                diff_field("left_seen", 32'(want.left_seen), 32'(m_left_seen));
                diff_field("right_seen", 32'(want.right_seen), 32'(m_right_seen));
                diff_field("passes_leftward", 32'(want.passes_leftward),
                           32'(m_passes_leftward));
                diff_field("passes_rightward", 32'(want.passes_rightward),
                           32'(m_passes_rightward));
                diff_field("stored", 32'(want.stored), 32'(m_stored));
                diff_field("log_count", 32'(want.log_count), 32'(m_log_count));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                compare_result();
            // a new token starts one long hold-off, counted here
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!rx_choppy) begin
                m_ready <= 1'b1;
            end else begin
                // alternating runs of ready and stall of random length
                if (run_left == 0) begin
                    rx_on    = ~rx_on;
                    run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                run_left--;
                m_ready <= rx_on;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [2:0] m, input logic [31:0] ts, input logic [4:0] ix);
        sensor_req_t rq;
        begin
            rq.mode = m;
            rq.ts   = ts;
            rq.idx  = ix;
            sensor_reqs.push_back(rq);
        end
    endtask

    // random timestamp, index biased toward the low log entries
    task automatic push_rnd(input logic [2:0] m);
        logic [4:0] ix;
        begin
            ix = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
            push_req(m, $urandom, ix);
        end
    endtask

    // wait until nothing is left to offer and nothing is outstanding
    task automatic wait_drained();
        begin
            while (sensor_reqs.size() != 0 || s_valid || pending_results.size() != 0)
                @(posedge aclk);
            repeat (8) @(posedge aclk);
        end
    endtask

    // window register write, only with the block quiet
    task automatic set_window(input tspd_pkg::cnt16_t v);
        begin
            wait_drained();
            @(posedge aclk);
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            tr_window = v;
        end
    endtask

    // mostly complete passages with random tick spacing, plus noise
    task automatic queue_random_traffic(input int n_items);
        int         made;
        int         k;
        int         r;
        logic [2:0] side;
        logic [2:0] other;
        logic [2:0] junk;
        begin
            made = 0;
            push_rnd(tspd_pkg::MODE_CLEAR);
            while (made < n_items) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    side  = $urandom_range(0, 1) ? tspd_pkg::MODE_LEFT
                                                 : tspd_pkg::MODE_RIGHT;
                    other = (side == tspd_pkg::MODE_LEFT) ? tspd_pkg::MODE_RIGHT
                                                          : tspd_pkg::MODE_LEFT;
                    // small windows get spacing around the expiry point
                    k = (tr_window <= 20) ? int'($urandom_range(0, tr_window + 1))
                                          : int'($urandom_range(0, 12));
                    push_rnd(side);
                    repeat (k) push_rnd(tspd_pkg::MODE_TICK);
                    if ($urandom_range(0, 9) == 0)
                        push_rnd(side);
                    push_rnd(other);
                    made += k + 2;
                end else if (r < 72) begin
                    push_rnd(tspd_pkg::MODE_READ);
                    made++;
                end else if (r < 84) begin
                    push_rnd(tspd_pkg::MODE_TICK);
                    made++;
                end else if (r < 93) begin
                    push_rnd($urandom_range(0, 1) ? tspd_pkg::MODE_LEFT
                                                  : tspd_pkg::MODE_RIGHT);
                    made++;
                end else if (r < 98) begin
                    junk = 3'($urandom_range(5, 7));
                    push_rnd(junk);
                end else begin
                    push_rnd(tspd_pkg::MODE_CLEAR);
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    int               n;
    tspd_pkg::cnt16_t w_mid;

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests against the reset window
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);             // tick while idle
        push_req(tspd_pkg::MODE_LEFT, 32'hFFFF_FFFF, 5'd31);    // arm left
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_LEFT, 32'h1234_5678, 5'd0);     // repeat on armed side
        push_req(tspd_pkg::MODE_RIGHT, 32'hFFFF_FFFF, 5'd31);   // passage rightward, delta 3
        push_req(tspd_pkg::MODE_RIGHT, 32'h0, 5'd0);            // arm right
        push_req(tspd_pkg::MODE_LEFT, 32'h0, 5'd31);            // passage leftward, delta 0
        push_req(tspd_pkg::MODE_READ, 32'hFFFF_FFFF, 5'd0);
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd1);
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd31);            // beyond stored count
        push_req(3'd5, 32'hFFFF_FFFF, 5'd31);                   // unused modes
        push_req(3'd6, 32'h0, 5'd0);
        push_req(3'd7, 32'hFFFF_FFFF, 5'd31);
        push_req(tspd_pkg::MODE_LEFT, 32'hA5A5_5A5A, 5'd0);     // arm, clear keeps arming
        push_req(tspd_pkg::MODE_CLEAR, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_RIGHT, 32'h5A5A_A5A5, 5'd0);
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_CLEAR, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd0);             // read after clear is beyond

        // shortest window: one tick abandons the armed side
        set_window(16'd1);
        push_req(tspd_pkg::MODE_LEFT, 32'h1, 5'd0);
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_RIGHT, 32'h2, 5'd0);            // arms, does not pair
        push_req(tspd_pkg::MODE_TICK, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_LEFT, 32'h3, 5'd0);
        push_req(tspd_pkg::MODE_RIGHT, 32'h4, 5'd0);            // pairs with delta 0
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd0);
        queue_random_traffic(125);

        // small random window, with a long receiver hold-off mid-traffic
        w_mid = tspd_pkg::cnt16_t'($urandom_range(2, 20));
        set_window(w_mid);
        queue_random_traffic(125);
        @(posedge aclk);
        hold_token <= hold_token + 1;

        // back to the reset value
        set_window(tspd_pkg::WINDOW_RESET);
        queue_random_traffic(125);

        // widest window, no idling: fill the log past its depth
        set_window(16'hFFFF);
        @(posedge aclk);
        tx_bursty <= 1'b0;
        rx_choppy <= 1'b0;
        push_req(tspd_pkg::MODE_CLEAR, 32'h0, 5'd0);
        for (n = 0; n < int'(tspd_pkg::LOG_DEPTH / 2) + 1; n++) begin
            push_req(tspd_pkg::MODE_LEFT, $urandom, 5'd0);
            push_req(tspd_pkg::MODE_RIGHT, $urandom, 5'd0);
            push_req(tspd_pkg::MODE_RIGHT, $urandom, 5'd0);
            push_req(tspd_pkg::MODE_LEFT, $urandom, 5'd0);
        end
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd31);            // last entry of a full log
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_CLEAR, 32'h0, 5'd0);
        push_req(tspd_pkg::MODE_READ, 32'h0, 5'd0);
        wait_drained();
        @(posedge aclk);
        tx_bursty <= 1'b1;
        rx_choppy <= 1'b1;

        // a last short window with the usual idling
        set_window(16'd3);
        queue_random_traffic(125);

        wait_drained();
        $display("run: %0d requests, %0d passages (%0d not logged), %0d reads, %0d beyond",
                 n_accepted, n_pass, n_dropped, n_read, n_beyond);
        $display("run: windows 1 to 65535, log filled past depth, long hold-off, gapless stretch");
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // watchdog
    int cycle_cnt = 0;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_cnt, pending_results.size());
        $display("tb: errors");
        $finish;
    end

endmodule
